>>> rtl/core/tsrl_pkg.sv
// ----------------------------------------------------------------------------
// tsrl_pkg
// Shared types and constants of the time-series range lookup: store geometry,
// operation and status codes, sequencer states and the memory request bundle.
// ----------------------------------------------------------------------------
package tsrl_pkg;

  // Store geometry
  localparam int unsigned DEPTH  = 1024;
  localparam int unsigned ADDR_W = $clog2(DEPTH);
  localparam int unsigned POS_W  = $clog2(DEPTH + 1);
  localparam int unsigned TIME_W = 64;

  // Timestamp that marks a null record
  localparam logic [TIME_W-1:0] NULL_TIME = '1;

  typedef enum logic [1:0] {
    OP_UPDATE = 2'd0,
    OP_INDEX  = 2'd1,
    OP_DATE   = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    STATUS_DONE     = 2'd0,
    STATUS_FULL     = 2'd1,
    STATUS_NULL     = 2'd2,
    STATUS_REPLACED = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPD_CHK,
    ST_IDX_RES,
    ST_IDX_CHK,
    ST_SRCH_ADDR,
    ST_SRCH_CMP
  } state_e;

  // One write port and one read port per cycle
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [TIME_W-1:0] wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

endpackage

>>> rtl/core/time_series_range_lookup.sv
// ----------------------------------------------------------------------------
// time_series_range_lookup
// Ascending timestamp store with append/replace updates and index or time
// range queries resolved to half-open store positions.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; its single result
// appears for one cycle with done_o high and cannot be held off. Timing per
// item is set by the sequencer and the registered read data of the store:
// an update with a null or first record finishes from idle, any other update
// reads the last entry and then checks it, and an index query resolves and then
// checks its bounds. A date query runs two lower-bound searches, each probe a
// read state plus a compare state, with at most ceil(log2(count+1)) probes per
// search. done_o rises the cycle busy falls, and a new item may be started in
// that same cycle.
module time_series_range_lookup (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  input  logic [1:0]                         operation_i,
  input  logic [tsrl_pkg::TIME_W-1:0]        record_time_i,
  input  logic signed [tsrl_pkg::TIME_W-1:0] start_index_i,
  input  logic signed [tsrl_pkg::TIME_W-1:0] end_index_i,
  input  logic [tsrl_pkg::TIME_W-1:0]        start_time_i,
  input  logic [tsrl_pkg::TIME_W-1:0]        end_time_i,
  output logic                               done_o,
  output logic                               found_o,
  output logic [tsrl_pkg::POS_W-1:0]         first_position_o,
  output logic [tsrl_pkg::POS_W-1:0]         end_position_o,
  output logic [1:0]                         status_o
);

  tsrl_pkg::mem_req_t          mem_req;
  logic [tsrl_pkg::TIME_W-1:0] mem_rdata;

  // Sequencer
  tsrl_ctrl u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .operation_i      (operation_i),
    .record_time_i    (record_time_i),
    .start_index_i    (start_index_i),
    .end_index_i      (end_index_i),
    .start_time_i     (start_time_i),
    .end_time_i       (end_time_i),
    .mem_req_o        (mem_req),
    .mem_rdata_i      (mem_rdata),
    .done_o           (done_o),
    .found_o          (found_o),
    .first_position_o (first_position_o),
    .end_position_o   (end_position_o),
    .status_o         (status_o)
  );

  // Timestamp store
  tsrl_mem u_mem (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  // Result strobe only once the sequencer is back to idle
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe while busy");

  // Every accepted transfer either completes at once or keeps the block busy
  a_accept_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy || done_o))
    else $error("accepted item neither busy nor done");

  // A found range is nonempty
  a_found_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && found_o) |-> (first_position_o < end_position_o))
    else $error("found range is empty");

  // Update statuses never come with a found range
  a_status_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o != tsrl_pkg::STATUS_DONE) |-> !found_o)
    else $error("update status with found flag");

endmodule

>>> rtl/core/tsrl_mem.sv
// ----------------------------------------------------------------------------
// tsrl_mem
// Timestamp store: single write port, single read port, registered read data.
// Contents are undefined until written.
// ----------------------------------------------------------------------------
module tsrl_mem (
  input  logic                           clk_i,
  input  tsrl_pkg::mem_req_t             req_i,
  output logic [tsrl_pkg::TIME_W-1:0]    rdata_o
);

  logic [tsrl_pkg::TIME_W-1:0] mem_q [tsrl_pkg::DEPTH];
  logic [tsrl_pkg::TIME_W-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
  end

  // Read port, data registered
  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rdata_q <= mem_q[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/tsrl_ctrl.sv
// ----------------------------------------------------------------------------
// tsrl_ctrl
// Sequencer of the range lookup: record count, update read-compare-write,
// index range resolution and the two lower-bound searches over the store.
// ----------------------------------------------------------------------------
module tsrl_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    operation_i,
  input  logic [tsrl_pkg::TIME_W-1:0]   record_time_i,
  input  logic signed [tsrl_pkg::TIME_W-1:0] start_index_i,
  input  logic signed [tsrl_pkg::TIME_W-1:0] end_index_i,
  input  logic [tsrl_pkg::TIME_W-1:0]   start_time_i,
  input  logic [tsrl_pkg::TIME_W-1:0]   end_time_i,
  output tsrl_pkg::mem_req_t            mem_req_o,
  input  logic [tsrl_pkg::TIME_W-1:0]   mem_rdata_i,
  output logic                          done_o,
  output logic                          found_o,
  output logic [tsrl_pkg::POS_W-1:0]    first_position_o,
  output logic [tsrl_pkg::POS_W-1:0]    end_position_o,
  output logic [1:0]                    status_o
);

  // Signed index to a store position: negatives wrap by count and saturate
  // at zero, positives saturate at count.
  function automatic logic [tsrl_pkg::POS_W-1:0] resolve_index(
    input logic [tsrl_pkg::TIME_W-1:0] raw,
    input logic [tsrl_pkg::POS_W-1:0]  n
  );
    logic [tsrl_pkg::TIME_W-1:0] mag;
    logic [tsrl_pkg::TIME_W-1:0] n_ext;
    logic [tsrl_pkg::POS_W-1:0]  r;
    n_ext = {{(tsrl_pkg::TIME_W - tsrl_pkg::POS_W){1'b0}}, n};
    mag   = ~raw + {{(tsrl_pkg::TIME_W - 1){1'b0}}, 1'b1};
    if (raw[tsrl_pkg::TIME_W-1]) begin
      if (mag >= n_ext) r = '0;
      else              r = n - mag[tsrl_pkg::POS_W-1:0];
    end else begin
      if (raw >= n_ext) r = n;
      else              r = raw[tsrl_pkg::POS_W-1:0];
    end
    return r;
  endfunction

  tsrl_pkg::state_e state_q, state_d;

  logic [tsrl_pkg::POS_W-1:0]  count_q, count_d;
  logic [tsrl_pkg::TIME_W-1:0] key_q, key_d;
  logic [tsrl_pkg::TIME_W-1:0] aux_q, aux_d;
  logic [tsrl_pkg::POS_W-1:0]  lo_q, lo_d;
  logic [tsrl_pkg::POS_W-1:0]  hi_q, hi_d;
  logic [tsrl_pkg::POS_W-1:0]  mid_q, mid_d;
  logic [tsrl_pkg::POS_W-1:0]  first_q, first_d;
  logic                        pass_q, pass_d;

  logic                        done_q, done_d;
  logic                        found_q, found_d;
  logic [tsrl_pkg::POS_W-1:0]  fpos_q, fpos_d;
  logic [tsrl_pkg::POS_W-1:0]  epos_q, epos_d;
  tsrl_pkg::status_e           status_q, status_d;

  tsrl_pkg::op_e               op;
  logic                        is_null;
  logic                        cnt_zero;
  logic                        cnt_full;
  logic                        date_bad;
  logic                        lo_lt_hi;
  logic                        lo_at_end;
  logic                        last_hit;
  logic                        below_key;
  logic [tsrl_pkg::POS_W:0]    mid_sum;
  logic [tsrl_pkg::POS_W-1:0]  mid;
  logic [tsrl_pkg::POS_W-1:0]  last_pos;

  // Shared decision flags
  assign op        = tsrl_pkg::op_e'(operation_i);
  assign is_null   = (record_time_i == tsrl_pkg::NULL_TIME);
  assign cnt_zero  = (count_q == '0);
  assign cnt_full  = (count_q >= tsrl_pkg::POS_W'(tsrl_pkg::DEPTH));
  assign date_bad  = (start_time_i >= end_time_i) || cnt_zero;
  assign lo_lt_hi  = (lo_q < hi_q);
  assign lo_at_end = (lo_q >= count_q);
  assign last_hit  = (mem_rdata_i == key_q);
  assign below_key = (mem_rdata_i < key_q);
  assign mid_sum   = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid       = mid_sum[tsrl_pkg::POS_W:1];
  assign last_pos  = count_q - tsrl_pkg::POS_W'(1);

  assign busy = (state_q != tsrl_pkg::ST_IDLE);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      tsrl_pkg::ST_IDLE: begin
        if (start) begin
          case (op)
            tsrl_pkg::OP_UPDATE: if (!is_null && !cnt_zero) state_d = tsrl_pkg::ST_UPD_CHK;
            tsrl_pkg::OP_INDEX:  state_d = tsrl_pkg::ST_IDX_RES;
            tsrl_pkg::OP_DATE:   if (!date_bad) state_d = tsrl_pkg::ST_SRCH_ADDR;
            default:             state_d = tsrl_pkg::ST_IDLE;
          endcase
        end
      end
      tsrl_pkg::ST_UPD_CHK:   state_d = tsrl_pkg::ST_IDLE;
      tsrl_pkg::ST_IDX_RES:   state_d = tsrl_pkg::ST_IDX_CHK;
      tsrl_pkg::ST_IDX_CHK:   state_d = tsrl_pkg::ST_IDLE;
      tsrl_pkg::ST_SRCH_ADDR: begin
        if (lo_lt_hi) begin
          state_d = tsrl_pkg::ST_SRCH_CMP;
        end else if (pass_q || lo_at_end) begin
          state_d = tsrl_pkg::ST_IDLE;
        end
      end
      tsrl_pkg::ST_SRCH_CMP:  state_d = tsrl_pkg::ST_SRCH_ADDR;
      default:                state_d = tsrl_pkg::ST_IDLE;
    endcase
  end

  // Datapath, memory requests and result
  always_comb begin
    count_d   = count_q;
    key_d     = key_q;
    aux_d     = aux_q;
    lo_d      = lo_q;
    hi_d      = hi_q;
    mid_d     = mid_q;
    first_d   = first_q;
    pass_d    = pass_q;
    done_d    = 1'b0;
    found_d   = found_q;
    fpos_d    = fpos_q;
    epos_d    = epos_q;
    status_d  = status_q;
    mem_req_o = '0;

    case (state_q)
      tsrl_pkg::ST_IDLE: begin
        if (start) begin
          case (op)
            tsrl_pkg::OP_UPDATE: begin
              key_d = record_time_i;
              if (is_null) begin
                done_d = 1'b1; found_d = 1'b0; fpos_d = '0; epos_d = '0;
                status_d = tsrl_pkg::STATUS_NULL;
              end else if (cnt_zero) begin
                // empty store: plain append
                mem_req_o.we    = 1'b1;
                mem_req_o.waddr = '0;
                mem_req_o.wdata = record_time_i;
                count_d = tsrl_pkg::POS_W'(1);
                done_d = 1'b1; found_d = 1'b0; fpos_d = '0; epos_d = '0;
                status_d = tsrl_pkg::STATUS_DONE;
              end else begin
                // fetch last entry for the replace check
                mem_req_o.re    = 1'b1;
                mem_req_o.raddr = last_pos[tsrl_pkg::ADDR_W-1:0];
              end
            end
            tsrl_pkg::OP_INDEX: begin
              key_d = start_index_i;
              aux_d = end_index_i;
            end
            tsrl_pkg::OP_DATE: begin
              key_d  = start_time_i;
              aux_d  = end_time_i;
              lo_d   = '0;
              hi_d   = count_q;
              pass_d = 1'b0;
              if (date_bad) begin
                done_d = 1'b1; found_d = 1'b0; fpos_d = '0; epos_d = '0;
                status_d = tsrl_pkg::STATUS_DONE;
              end
            end
            default: begin
              done_d = 1'b1; found_d = 1'b0; fpos_d = '0; epos_d = '0;
              status_d = tsrl_pkg::STATUS_DONE;
            end
          endcase
        end
      end

      // Replace, drop or append against the last entry
      tsrl_pkg::ST_UPD_CHK: begin
        done_d = 1'b1; found_d = 1'b0; fpos_d = '0; epos_d = '0;
        if (last_hit) begin
          status_d = tsrl_pkg::STATUS_REPLACED;
        end else if (cnt_full) begin
          status_d = tsrl_pkg::STATUS_FULL;
        end else begin
          mem_req_o.we    = 1'b1;
          mem_req_o.waddr = count_q[tsrl_pkg::ADDR_W-1:0];
          mem_req_o.wdata = key_q;
          count_d  = count_q + tsrl_pkg::POS_W'(1);
          status_d = tsrl_pkg::STATUS_DONE;
        end
      end

      // Index bounds to clamped positions
      tsrl_pkg::ST_IDX_RES: begin
        lo_d = resolve_index(key_q, count_q);
        hi_d = resolve_index(aux_q, count_q);
      end

      tsrl_pkg::ST_IDX_CHK: begin
        done_d   = 1'b1;
        status_d = tsrl_pkg::STATUS_DONE;
        found_d  = lo_lt_hi;
        fpos_d   = lo_lt_hi ? lo_q : '0;
        epos_d   = lo_lt_hi ? hi_q : '0;
      end

      // Probe issue, or end of a search pass
      tsrl_pkg::ST_SRCH_ADDR: begin
        if (lo_lt_hi) begin
          mem_req_o.re    = 1'b1;
          mem_req_o.raddr = mid[tsrl_pkg::ADDR_W-1:0];
          mid_d           = mid;
        end else if (!pass_q) begin
          if (lo_at_end) begin
            done_d = 1'b1; found_d = 1'b0; fpos_d = '0; epos_d = '0;
            status_d = tsrl_pkg::STATUS_DONE;
          end else begin
            // second search from the first position up to the end time
            first_d = lo_q;
            key_d   = aux_q;
            hi_d    = count_q;
            pass_d  = 1'b1;
          end
        end else begin
          done_d   = 1'b1;
          status_d = tsrl_pkg::STATUS_DONE;
          found_d  = (first_q < lo_q);
          fpos_d   = (first_q < lo_q) ? first_q : '0;
          epos_d   = (first_q < lo_q) ? lo_q : '0;
        end
      end

      // Narrow the bounds on the probed entry
      tsrl_pkg::ST_SRCH_CMP: begin
        if (below_key) lo_d = mid_q + tsrl_pkg::POS_W'(1);
        else           hi_d = mid_q;
      end

      default: begin
        done_d = 1'b0;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tsrl_pkg::ST_IDLE;
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      done_q  <= done_d;
    end
  end

  // Working and result registers
  always_ff @(posedge clk_i) begin
    key_q    <= key_d;
    aux_q    <= aux_d;
    lo_q     <= lo_d;
    hi_q     <= hi_d;
    mid_q    <= mid_d;
    first_q  <= first_d;
    pass_q   <= pass_d;
    found_q  <= found_d;
    fpos_q   <= fpos_d;
    epos_q   <= epos_d;
    status_q <= status_d;
  end

  assign done_o           = done_q;
  assign found_o          = found_q;
  assign first_position_o = fpos_q;
  assign end_position_o   = epos_q;
  assign status_o         = status_q;

endmodule
